/* rtl/imf_pkg.sv */
`default_nettype none
package imf_pkg;
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int GAMMA_BITS = 18;
    localparam int QUO_BITS = WORD_BITS + FRAC_BITS + 1;
    localparam int DIV_STEPS = 2;
    localparam int DIV_STAGES = (QUO_BITS + DIV_STEPS - 1) / DIV_STEPS;

    localparam logic [GAMMA_BITS-1:0] GAMMA_RESET = 18'd109227;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_BAD_DENSITY = 2'd1;
    localparam logic [1:0] ST_SATURATED = 2'd2;

    typedef logic signed [WORD_BITS-1:0] t_word;

    typedef struct packed {
        t_word field_z;
        t_word field_y;
        t_word field_x;
        t_word total_energy;
        t_word momentum_z;
        t_word momentum_y;
        t_word momentum_x;
        t_word density;
    } t_point;

    typedef struct packed {
        t_word field_flux_z;
        t_word field_flux_y;
        t_word energy_flux;
        t_word momentum_flux_z;
        t_word momentum_flux_y;
        t_word momentum_flux_x;
        t_word mass_flux;
    } t_flux;

    typedef struct packed {
        logic  ov;
        t_word v;
    } t_fx;

    localparam t_word WORD_MAX = t_word'({1'b0, {(WORD_BITS-1){1'b1}}});
    localparam t_word WORD_MIN = t_word'({1'b1, {(WORD_BITS-1){1'b0}}});
    localparam t_word FX_ONE = t_word'(64'd1 << FRAC_BITS);
    localparam t_word FX_HALF = t_word'(64'd1 << (FRAC_BITS - 1));

    function automatic t_fx fx_add(input t_word a, input t_word b);
        logic signed [WORD_BITS:0] s;
        t_fx r;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        r.ov = (s[WORD_BITS] != s[WORD_BITS-1]);
        r.v = r.ov ? (s[WORD_BITS] ? WORD_MIN : WORD_MAX) : s[WORD_BITS-1:0];
        return r;
    endfunction

    function automatic t_fx fx_sub(input t_word a, input t_word b);
        logic signed [WORD_BITS:0] s;
        t_fx r;
        s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
        r.ov = (s[WORD_BITS] != s[WORD_BITS-1]);
        r.v = r.ov ? (s[WORD_BITS] ? WORD_MIN : WORD_MAX) : s[WORD_BITS-1:0];
        return r;
    endfunction

    function automatic t_fx fx_mul(input t_word a, input t_word b);
        logic                         neg;
        logic [WORD_BITS-1:0]         ma;
        logic [WORD_BITS-1:0]         mb;
        logic [2*WORD_BITS-1:0]       prod;
        logic [2*WORD_BITS:0]         p;
        logic [2*WORD_BITS-FRAC_BITS:0] q;
        logic [2*WORD_BITS-FRAC_BITS:0] lim;
        t_fx r;
        neg = a[WORD_BITS-1] ^ b[WORD_BITS-1];
        ma = a[WORD_BITS-1] ? WORD_BITS'(-a) : WORD_BITS'(a);
        mb = b[WORD_BITS-1] ? WORD_BITS'(-b) : WORD_BITS'(b);
        prod = (2*WORD_BITS)'(ma) * (2*WORD_BITS)'(mb);
        p = {1'b0, prod} + ((2*WORD_BITS+1)'(1) << (FRAC_BITS - 1));
        q = p[2*WORD_BITS:FRAC_BITS];
        lim = (2*WORD_BITS-FRAC_BITS+1)'(WORD_MAX) + (2*WORD_BITS-FRAC_BITS+1)'(neg);
        r.ov = (q > lim);
        if (r.ov) begin
            q = lim;
        end
        r.v = neg ? t_word'(-q[WORD_BITS-1:0]) : t_word'(q[WORD_BITS-1:0]);
        return r;
    endfunction
endpackage
`default_nettype wire

/* rtl/imf_div.sv */
`default_nettype none
module imf_div (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire imf_pkg::t_point i_pt,
    output logic                o_valid,
    output imf_pkg::t_point     o_pt,
    output imf_pkg::t_word      o_u1,
    output imf_pkg::t_word      o_u2,
    output imf_pkg::t_word      o_u3,
    output logic                o_ov
);
    import imf_pkg::*;

    logic [WORD_BITS-1:0] r_rem [DIV_STAGES][3];
    logic [QUO_BITS-1:0]  r_nq  [DIV_STAGES][3];
    t_point               r_pt  [DIV_STAGES];
    logic                 r_v   [DIV_STAGES];
    t_word                r_u [3];
    logic                 r_ov;
    t_point               r_opt;
    logic                 r_ov_v;

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [WORD_BITS-1:0] n_rem [3];
        logic [QUO_BITS-1:0]  n_nq  [3];
        t_point               w_pt;
        always_comb begin
            logic [WORD_BITS-1:0] mb;
            logic [WORD_BITS:0]   rs;
            logic [WORD_BITS-1:0] ma;
            w_pt = (s == 0) ? i_pt : r_pt[(s == 0) ? 0 : s-1];
            mb = w_pt.density;
            for (int l = 0; l < 3; l++) begin
                if (s == 0) begin
                    ma = (l == 0) ? i_pt.momentum_x : (l == 1) ? i_pt.momentum_y
                                                               : i_pt.momentum_z;
                    if (ma[WORD_BITS-1]) begin
                        ma = -ma;
                    end
                    n_rem[l] = '0;
                    n_nq[l] = {ma, {(QUO_BITS-WORD_BITS){1'b0}}};
                end else begin
                    n_rem[l] = r_rem[(s == 0) ? 0 : s-1][l];
                    n_nq[l] = r_nq[(s == 0) ? 0 : s-1][l];
                end
                for (int k = 0; k < DIV_STEPS; k++) begin
                    if (s * DIV_STEPS + k < QUO_BITS) begin
                        rs = {n_rem[l], n_nq[l][QUO_BITS-1]};
                        if (rs >= {1'b0, mb}) begin
                            rs = rs - {1'b0, mb};
                            n_nq[l] = {n_nq[l][QUO_BITS-2:0], 1'b1};
                        end else begin
                            n_nq[l] = {n_nq[l][QUO_BITS-2:0], 1'b0};
                        end
                        n_rem[l] = rs[WORD_BITS-1:0];
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= (s == 0) ? i_valid : r_v[(s == 0) ? 0 : s-1];
            end
            if (i_en) begin
                r_pt[s] <= w_pt;
                for (int l = 0; l < 3; l++) begin
                    r_rem[s][l] <= n_rem[l];
                    r_nq[s][l] <= n_nq[l];
                end
            end
        end
    end

    // round half away, then saturate with the sign of the numerator
    t_word n_u [3];
    logic  n_ov;
    always_comb begin
        logic [QUO_BITS:0]   q;
        logic [QUO_BITS-1:0] lim;
        logic                neg;
        t_point              pt;
        pt = r_pt[DIV_STAGES-1];
        n_ov = 1'b0;
        for (int l = 0; l < 3; l++) begin
            neg = (l == 0) ? pt.momentum_x[WORD_BITS-1] :
                  (l == 1) ? pt.momentum_y[WORD_BITS-1] : pt.momentum_z[WORD_BITS-1];
            q = ({1'b0, r_nq[DIV_STAGES-1][l]} + (QUO_BITS+1)'(1)) >> 1;
            lim = QUO_BITS'(WORD_MAX) + QUO_BITS'(neg);
            if (q[QUO_BITS-1:0] > lim) begin
                n_ov = 1'b1;
                q = {1'b0, lim};
            end
            n_u[l] = neg ? t_word'(-q[WORD_BITS-1:0]) : t_word'(q[WORD_BITS-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov_v <= 1'b0;
        end else if (i_en) begin
            r_ov_v <= r_v[DIV_STAGES-1];
        end
        if (i_en) begin
            r_u <= n_u;
            r_ov <= n_ov;
            r_opt <= r_pt[DIV_STAGES-1];
        end
    end

    assign o_valid = r_ov_v;
    assign o_pt = r_opt;
    assign o_u1 = r_u[0];
    assign o_u2 = r_u[1];
    assign o_u3 = r_u[2];
    assign o_ov = r_ov;
endmodule
`default_nettype wire

/* rtl/imf_flux.sv */
`default_nettype none
module imf_flux (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire imf_pkg::t_point              i_pt,
    input  wire imf_pkg::t_word               i_u1,
    input  wire imf_pkg::t_word               i_u2,
    input  wire imf_pkg::t_word               i_u3,
    input  wire logic                         i_ov,
    input  wire logic [imf_pkg::GAMMA_BITS-1:0] i_gamma,
    output logic                              o_valid,
    output imf_pkg::t_flux                    o_flux,
    output logic [1:0]                        o_status
);
    import imf_pkg::*;

    logic [7:0] r_v;
    t_flux r_f1, r_f2, r_f3, r_f4, r_f5, r_f6, r_f7, r_f8;
    logic  r_ov1, r_ov2, r_ov3, r_ov4, r_ov5, r_ov6, r_ov7;
    logic  r_pos1, r_pos2, r_pos3, r_pos4, r_pos5, r_pos6, r_pos7;
    logic [1:0] r_st8;
    t_word r1_uu1, r1_uu2, r1_uu3, r1_hr, r1_b11, r1_b22, r1_b33;
    t_word r1_ub1, r1_ub2, r1_ub3, r1_u2b1, r1_u3b1, r1_b1b2, r1_b1b3;
    t_word r1_u1, r1_u2, r1_u3, r1_gm1, r1_en, r1_b1;
    t_word r2_ksum, r2_bsq, r2_bu, r2_m1x, r2_m2, r2_m3, r2_hr, r2_b11;
    t_word r2_b1b2, r2_b1b3, r2_gm1, r2_en, r2_b1, r2_u1;
    t_word r3_rke, r3_bm, r3_b1bu, r3_m1x, r3_b11, r3_gm1, r3_en, r3_u1;
    t_word r4_t, r4_bm, r4_b1bu, r4_m1x, r4_b11, r4_gm1, r4_en, r4_u1;
    t_word r5_p, r5_bm, r5_b1bu, r5_m1x, r5_b11, r5_en, r5_u1;
    t_word r6_e, r6_b1bu, r6_u1;
    t_word r7_eu, r7_b1bu;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[6:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        t_fx a, b, c, d, e, f, g, h, m, n, o, p, q, s, t, x, y;
        t_flux tf;
        if (i_en) begin
            // stage 1: products of the inputs and velocities
            a = fx_mul(i_u1, i_u1);
            b = fx_mul(i_u2, i_u2);
            c = fx_mul(i_u3, i_u3);
            d = fx_mul(FX_HALF, i_pt.density);
            e = fx_mul(i_pt.field_x, i_pt.field_x);
            f = fx_mul(i_pt.field_y, i_pt.field_y);
            g = fx_mul(i_pt.field_z, i_pt.field_z);
            h = fx_mul(i_u1, i_pt.field_x);
            m = fx_mul(i_u2, i_pt.field_y);
            n = fx_mul(i_u3, i_pt.field_z);
            o = fx_mul(i_u2, i_pt.field_x);
            p = fx_mul(i_u3, i_pt.field_x);
            q = fx_mul(i_pt.field_x, i_pt.field_y);
            s = fx_mul(i_pt.field_x, i_pt.field_z);
            t = fx_mul(i_pt.density, i_u1);
            x = fx_mul(i_u1, i_pt.field_y);
            y = fx_mul(i_u1, i_pt.field_z);
            tf = '0;
            tf.mass_flux = t.v;
            tf.field_flux_y = x.v;
            tf.field_flux_z = y.v;
            r_f1 <= tf;
            r_pos1 <= !i_pt.density[WORD_BITS-1] && (i_pt.density != '0);
            r1_uu1 <= a.v; r1_uu2 <= b.v; r1_uu3 <= c.v; r1_hr <= d.v;
            r1_b11 <= e.v; r1_b22 <= f.v; r1_b33 <= g.v;
            r1_ub1 <= h.v; r1_ub2 <= m.v; r1_ub3 <= n.v;
            r1_u2b1 <= o.v; r1_u3b1 <= p.v; r1_b1b2 <= q.v; r1_b1b3 <= s.v;
            r1_u1 <= i_u1; r1_u2 <= i_u2; r1_u3 <= i_u3;
            r1_en <= i_pt.total_energy; r1_b1 <= i_pt.field_x;
            r1_gm1 <= t_word'({1'b0, i_gamma}) - FX_ONE;
            r_ov1 <= i_ov | a.ov | b.ov | c.ov | d.ov | e.ov | f.ov | g.ov | h.ov
                     | m.ov | n.ov | o.ov | p.ov | q.ov | s.ov | t.ov | x.ov | y.ov;

            // stage 2: sums and flux products
            a = fx_add(r1_uu1, r1_uu2);
            b = fx_add(a.v, r1_uu3);
            c = fx_add(r1_b11, r1_b22);
            d = fx_add(c.v, r1_b33);
            e = fx_add(r1_ub1, r1_ub2);
            f = fx_add(e.v, r1_ub3);
            g = fx_mul(r_f1.mass_flux, r1_u1);
            h = fx_mul(r_f1.mass_flux, r1_u2);
            m = fx_mul(r_f1.mass_flux, r1_u3);
            n = fx_sub(r_f1.field_flux_y, r1_u2b1);
            o = fx_sub(r_f1.field_flux_z, r1_u3b1);
            r2_ksum <= b.v; r2_bsq <= d.v; r2_bu <= f.v;
            r2_m1x <= g.v; r2_m2 <= h.v; r2_m3 <= m.v;
            tf = r_f1;
            tf.field_flux_y = n.v;
            tf.field_flux_z = o.v;
            r_f2 <= tf;
            r_ov2 <= r_ov1 | a.ov | b.ov | c.ov | d.ov | e.ov | f.ov | g.ov | h.ov
                     | m.ov | n.ov | o.ov;
            r_pos2 <= r_pos1;
            r2_hr <= r1_hr; r2_b11 <= r1_b11; r2_b1b2 <= r1_b1b2; r2_b1b3 <= r1_b1b3;
            r2_gm1 <= r1_gm1; r2_en <= r1_en; r2_b1 <= r1_b1; r2_u1 <= r1_u1;

            // stage 3: kinetic and magnetic pressure, y and z momentum fluxes
            a = fx_mul(r2_hr, r2_ksum);
            b = fx_mul(FX_HALF, r2_bsq);
            c = fx_mul(r2_b1, r2_bu);
            d = fx_sub(r2_m2, r2_b1b2);
            e = fx_sub(r2_m3, r2_b1b3);
            r3_rke <= a.v; r3_bm <= b.v; r3_b1bu <= c.v;
            tf = r_f2;
            tf.momentum_flux_y = d.v;
            tf.momentum_flux_z = e.v;
            r_f3 <= tf;
            r_ov3 <= r_ov2 | a.ov | b.ov | c.ov | d.ov | e.ov;
            r_pos3 <= r_pos2;
            r3_m1x <= r2_m1x; r3_b11 <= r2_b11; r3_gm1 <= r2_gm1;
            r3_en <= r2_en; r3_u1 <= r2_u1;

            // stage 4: internal energy
            a = fx_sub(r3_en, r3_rke);
            b = fx_sub(a.v, r3_bm);
            r4_t <= b.v;
            r_ov4 <= r_ov3 | a.ov | b.ov;
            r_f4 <= r_f3; r_pos4 <= r_pos3;
            r4_bm <= r3_bm; r4_b1bu <= r3_b1bu; r4_m1x <= r3_m1x; r4_b11 <= r3_b11;
            r4_gm1 <= r3_gm1; r4_en <= r3_en; r4_u1 <= r3_u1;

            // stage 5: gas pressure
            a = fx_mul(r4_gm1, r4_t);
            r5_p <= a.v;
            r_ov5 <= r_ov4 | a.ov;
            r_f5 <= r_f4; r_pos5 <= r_pos4;
            r5_bm <= r4_bm; r5_b1bu <= r4_b1bu; r5_m1x <= r4_m1x; r5_b11 <= r4_b11;
            r5_en <= r4_en; r5_u1 <= r4_u1;

            // stage 6: x momentum flux and energy plus pressure
            a = fx_add(r5_m1x, r5_p);
            b = fx_add(a.v, r5_bm);
            c = fx_sub(b.v, r5_b11);
            e = fx_add(r5_en, r5_p);
            d = fx_add(e.v, r5_bm);
            tf = r_f5;
            tf.momentum_flux_x = c.v;
            r_f6 <= tf;
            r6_e <= d.v;
            r_ov6 <= r_ov5 | a.ov | b.ov | c.ov | d.ov | e.ov;
            r_pos6 <= r_pos5; r6_b1bu <= r5_b1bu; r6_u1 <= r5_u1;

            // stage 7: energy transport
            a = fx_mul(r6_u1, r6_e);
            r7_eu <= a.v;
            r_ov7 <= r_ov6 | a.ov;
            r_f7 <= r_f6; r_pos7 <= r_pos6; r7_b1bu <= r6_b1bu;

            // stage 8: output register
            a = fx_sub(r7_eu, r7_b1bu);
            tf = r_f7;
            tf.energy_flux = a.v;
            if (r_pos7) begin
                r_f8 <= tf;
                r_st8 <= (r_ov7 | a.ov) ? ST_SATURATED : ST_OK;
            end else begin
                r_f8 <= '0;
                r_st8 <= ST_BAD_DENSITY;
            end
        end
    end

    assign o_valid = r_v[7];
    assign o_flux = r_f8;
    assign o_status = r_st8;

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_BAD_DENSITY) |-> (o_flux == '0))
        else $error("bad density result carries flux");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_BAD_DENSITY
                     || o_status == ST_SATURATED))
        else $error("undefined status");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_v))
        else $error("valid bits moved during stall");
endmodule
`default_nettype wire

/* rtl/ideal_mhd_flux_1d.sv */
`default_nettype none
// Ideal MHD x-direction flux of one grid point in signed Q16.16. One point can be
// accepted every clock cycle while the output is not stalled. A 49-step pipelined
// restoring divider (two quotient bits per stage, 25 stages plus a rounding stage)
// is followed by an 8-stage multiply/add pipeline. The whole pipeline holds while a
// finished result waits and the output is not taken. Status in tuser: 0 ok, 1
// non-positive density (fluxes zero), 2 some result saturated. The user must write
// the gamma register only while the block is empty; the block does not enforce this.
module ideal_mhd_flux_1d (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // density, momentum_x, momentum_y, momentum_z, total_energy, field_x, field_y, field_z
    input  wire logic [255:0] i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // mass_flux, momentum_flux_x, momentum_flux_y, momentum_flux_z, energy_flux,
    // field_flux_y, field_flux_z
    output logic [223:0]      o_m_axis_tdata,
    // status
    output logic [1:0]        o_m_axis_tuser,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [17:0]  i_cfg_data
);
    import imf_pkg::*;

    logic [GAMMA_BITS-1:0] r_gamma;
    logic   w_en;
    logic   w_dv;
    t_point w_pt;
    t_word  w_u1, w_u2, w_u3;
    logic   w_ov;
    t_flux  w_flux;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma <= GAMMA_RESET;
        end else if (i_cfg_valid) begin
            r_gamma <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign w_en = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    imf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_pt    (t_point'(i_s_axis_tdata)),
        .o_valid (w_dv),
        .o_pt    (w_pt),
        .o_u1    (w_u1),
        .o_u2    (w_u2),
        .o_u3    (w_u3),
        .o_ov    (w_ov)
    );

    imf_flux u_flux (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_dv),
        .i_pt     (w_pt),
        .i_u1     (w_u1),
        .i_u2     (w_u2),
        .i_u3     (w_u3),
        .i_ov     (w_ov),
        .i_gamma  (r_gamma),
        .o_valid  (o_m_axis_tvalid),
        .o_flux   (w_flux),
        .o_status (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = w_flux;

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("input ready does not follow output side");
    a_out_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");
    a_gamma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg_valid |=> $stable(r_gamma))
        else $error("gamma changed without a write");
endmodule
`default_nettype wire

/* tb/ideal_mhd_flux_1d_check.sv */
`default_nettype none
module ideal_mhd_flux_1d_check (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    input  wire logic         i_s_tready,
    input  wire logic [255:0] i_s_tdata,
    input  wire logic         i_m_tvalid,
    input  wire logic         i_m_tready,
    input  wire logic [223:0] i_m_tdata,
    input  wire logic [1:0]   i_m_tuser,
    input  wire logic         i_cfg_valid,
    input  wire logic         i_cfg_ready,
    input  wire logic [17:0]  i_cfg_data,
    output int                o_errors,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import imf_pkg::*;

    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;

    typedef struct {
        t_flux      flux;
        logic [1:0] status;
    } t_flux_result;

    t_flux_result flux_queue[$];
    logic [17:0]  gamma_reg;
    bit           sat_seen;

    function automatic longint clamp_sat(longint v);
        if (v > WMAX) begin
            sat_seen = 1;
            return WMAX;
        end
        if (v < WMIN) begin
            sat_seen = 1;
            return WMIN;
        end
        return v;
    endfunction

    function automatic longint q_add(longint a, longint b);
        return clamp_sat(a + b);
    endfunction

    function automatic longint q_sub(longint a, longint b);
        return clamp_sat(a - b);
    endfunction

    function automatic longint signed_mag(longint unsigned q, bit neg);
        longint unsigned lim;
        lim = 64'd2147483647 + (neg ? 64'd1 : 64'd0);
        if (q > lim) begin
            sat_seen = 1;
            q = lim;
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint q_mul(longint a, longint b);
        bit neg;
        longint unsigned ma, mb, p;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        p = ma * mb + (64'd1 << (FRAC_BITS - 1));
        return signed_mag(p >> FRAC_BITS, neg);
    endfunction

    function automatic longint q_div(longint a, longint b);
        bit neg;
        longint unsigned ma, mb, n, q, r;
        neg = a < 0;
        ma = (a < 0) ? -a : a;
        mb = b;
        n = ma << FRAC_BITS;
        q = n / mb;
        r = n % mb;
        if (2 * r >= mb) q++;
        return signed_mag(q, neg);
    endfunction

    function automatic t_flux_result flux_of(t_point pt, logic [17:0] g);
        t_flux_result res;
        longint rho, m1, m2, m3, en, b1, b2, b3;
        longint u1, u2, u3, ksum, rke, bsq, bm, gm1, press, bu, ru1;
        longint half, one;
        rho = pt.density;
        m1 = pt.momentum_x;
        m2 = pt.momentum_y;
        m3 = pt.momentum_z;
        en = pt.total_energy;
        b1 = pt.field_x;
        b2 = pt.field_y;
        b3 = pt.field_z;
        half = 64'sd1 << (FRAC_BITS - 1);
        one = 64'sd1 << FRAC_BITS;
        res.flux = '0;
        if (rho <= 0) begin
            res.status = ST_BAD_DENSITY;
            return res;
        end
        sat_seen = 0;
        u1 = q_div(m1, rho);
        u2 = q_div(m2, rho);
        u3 = q_div(m3, rho);
        ksum = q_add(q_add(q_mul(u1, u1), q_mul(u2, u2)), q_mul(u3, u3));
        rke = q_mul(q_mul(half, rho), ksum);
        bsq = q_add(q_add(q_mul(b1, b1), q_mul(b2, b2)), q_mul(b3, b3));
        bm = q_mul(half, bsq);
        gm1 = q_sub(longint'(g), one);
        press = q_mul(gm1, q_sub(q_sub(en, rke), bm));
        bu = q_add(q_add(q_mul(u1, b1), q_mul(u2, b2)), q_mul(u3, b3));
        ru1 = q_mul(rho, u1);
        res.flux.mass_flux = t_word'(ru1);
        res.flux.momentum_flux_x =
            t_word'(q_sub(q_add(q_add(q_mul(ru1, u1), press), bm), q_mul(b1, b1)));
        res.flux.momentum_flux_y = t_word'(q_sub(q_mul(ru1, u2), q_mul(b1, b2)));
        res.flux.momentum_flux_z = t_word'(q_sub(q_mul(ru1, u3), q_mul(b1, b3)));
        res.flux.energy_flux =
            t_word'(q_sub(q_mul(u1, q_add(q_add(en, press), bm)), q_mul(b1, bu)));
        res.flux.field_flux_y = t_word'(q_sub(q_mul(u1, b2), q_mul(u2, b1)));
        res.flux.field_flux_z = t_word'(q_sub(q_mul(u1, b3), q_mul(u3, b1)));
        res.status = sat_seen ? ST_SATURATED : ST_OK;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_flux_result want;
        t_flux        got;
        int           errs;
        errs = 0;
        if (!i_rst_n) begin
            gamma_reg <= GAMMA_RESET;
            flux_queue.delete();
            o_errors <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                gamma_reg <= i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                flux_queue.push_back(flux_of(t_point'(i_s_tdata), gamma_reg));
            end
            if (i_m_tvalid && i_m_tready) begin
                got = t_flux'(i_m_tdata);
                if (flux_queue.size() == 0) begin
                    $display("%0t: unexpected result %h status %0d", $time, i_m_tdata,
                             i_m_tuser);
                    errs++;
                end else begin
                    want = flux_queue.pop_front();
                    for (int k = 0; k < 7; k++) begin
                        if (want.flux[k*32 +: 32] !== got[k*32 +: 32]) begin
                            $display("%0t: flux word %0d expected %h actual %h", $time, k,
                                     want.flux[k*32 +: 32], got[k*32 +: 32]);
                            errs++;
                        end
                    end
                    if (want.status !== i_m_tuser) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, i_m_tuser);
                        errs++;
                    end
                end
            end
            o_errors <= o_errors + errs;
            o_pending <= flux_queue.size();
        end
    end
endmodule
`default_nettype wire

/* tb/ideal_mhd_flux_1d_test.sv */
`default_nettype none
module ideal_mhd_flux_1d_test;
    timeunit 1ns;
    timeprecision 1ps;
    import imf_pkg::*;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [255:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [223:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [17:0]  cfg_data = '0;
    int           errors;
    int           pending;
    bit           rx_long;

    ideal_mhd_flux_1d uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata),
        .o_m_axis_tuser(m_tuser),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data(cfg_data)
    );

    ideal_mhd_flux_1d_check checker_i (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid),
        .i_s_tready(s_tready),
        .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .i_m_tdata(m_tdata),
        .i_m_tuser(m_tuser),
        .i_cfg_valid(cfg_valid),
        .i_cfg_ready(cfg_ready),
        .i_cfg_data(cfg_data),
        .o_errors(errors),
        .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // receiver stalls, with stretches of no stalling
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) rx_long = ~rx_long;
        if (rx_long) m_tready = 1'b1;
        else m_tready = (gap_len() == 0);
    end

    function automatic t_word small_val(int bits);
        return t_word'($signed($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1)));
    endfunction

    function automatic t_point rand_point();
        t_point p;
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 2) begin
            p = {$urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom};
        end else begin
            p.density = t_word'($urandom_range(32'h0000_1000, 32'h0008_0000));
            p.momentum_x = small_val(20);
            p.momentum_y = small_val(20);
            p.momentum_z = small_val(20);
            p.total_energy = small_val(24);
            p.field_x = small_val(19);
            p.field_y = small_val(19);
            p.field_z = small_val(19);
            if (mode == 9) p.density = t_word'($urandom_range(1, 255));
            if (mode == 8) p.total_energy = t_word'($urandom);
        end
        return p;
    endfunction

    task automatic send_point(t_point p);
        s_tdata = p;
        s_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
        s_tvalid = 1'b0;
        repeat (gap_len()) @(negedge i_clk);
    endtask

    task automatic write_gamma(logic [17:0] g);
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        cfg_data = g;
        cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    task automatic directed_points();
        t_point p;
        p = '0;
        send_point(p);
        p.density = WORD_MIN;
        send_point(p);
        p = {8{32'hffff_ffff}};
        send_point(p);
        p = '0;
        p.density = FX_ONE;
        send_point(p);
        p = {8{WORD_MAX}};
        send_point(p);
        p = {{7{WORD_MIN}}, WORD_MAX};
        send_point(p);
        p = {{7{WORD_MAX}}, 32'sd1};
        send_point(p);
        p = {{7{WORD_MIN}}, 32'sd1};
        send_point(p);
        p.density = FX_ONE;
        p.momentum_x = 32'sh0002_0000;
        p.momentum_y = -32'sh0001_0000;
        p.momentum_z = 32'sh0000_8000;
        p.total_energy = 32'sh000a_0000;
        p.field_x = 32'sh0000_c000;
        p.field_y = -32'sh0001_4000;
        p.field_z = 32'sh0000_4000;
        send_point(p);
        p.density = 32'sd3;
        p.momentum_x = 32'sd1;
        send_point(p);
        p.density = 32'sh0003_0000;
        p.momentum_x = -32'sh0001_0000;
        send_point(p);
    endtask

    initial begin
        logic [17:0] gammas[7];
        gammas = '{18'd109227, 18'd65536, 18'd196608, 18'd32768, 18'd0, 18'h3ffff, 18'd98304};
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        directed_points();
        for (int ph = 0; ph < 8; ph++) begin
            write_gamma(ph < 7 ? gammas[ph] : 18'($urandom_range(65536, 196608)));
            if (ph == 3) directed_points();
            repeat (56) send_point(rand_point());
        end
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire
